// ===== hw/rtl/pms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants of the melody sequencer: actions, the item and
// result layouts, and the default sizes of the note store.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int unsigned SongDepthDefault  = 256;
  localparam int unsigned PeriodBitsDefault = 16;
  localparam int unsigned LengthBitsDefault = 24;

  localparam int unsigned IdxW      = 8;
  localparam int unsigned PeriodInW = 16;
  localparam int unsigned OctW      = 3;
  localparam int unsigned LenInW    = 24;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActWrite = 2'd1,
    ActStart = 2'd2,
    ActStop  = 2'd3
  } pms_action_e;

  typedef struct packed {
    pms_action_e          action;
    logic [IdxW-1:0]      entry_index;
    logic [PeriodInW-1:0] note_period;
    logic [OctW-1:0]      note_octave;
    logic [LenInW-1:0]    note_length;
  } pms_item_t;

  typedef struct packed {
    logic            tone_out;
    logic            busy_res;
    logic [IdxW-1:0] current_slot;
    logic            song_done;
  } pms_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pms_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_item_if / pms_result_if
// Valid/ready channels of the melody sequencer: command items in, one
// result item out per command.
// ----------------------------------------------------------------------------
interface pms_item_if import pms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [IdxW-1:0]      entry_index;
  logic [PeriodInW-1:0] note_period;
  logic [OctW-1:0]      note_octave;
  logic [LenInW-1:0]    note_length;

  modport source (
    output valid, action, entry_index, note_period, note_octave, note_length,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, note_period, note_octave, note_length,
    output ready
  );
endinterface

interface pms_result_if import pms_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            tone_out;
  logic            busy_res;
  logic [IdxW-1:0] current_slot;
  logic            song_done;

  modport source (
    output valid, tone_out, busy_res, current_slot, song_done,
    input  ready
  );
  modport sink (
    input  valid, tone_out, busy_res, current_slot, song_done,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/pms_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_in_stage
// Input register: captures one command item and holds it until the player
// takes it.
// ----------------------------------------------------------------------------
module pms_in_stage import pms_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  pms_item_if.sink       in_i,
  input  wire logic      adv_i,
  output pms_item_t      item_o,
  output logic           valid_o
);

  logic      valid_q;
  pms_item_t item_q;
  logic      accept;

  assign in_i.ready = !valid_q || adv_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action      <= pms_action_e'(in_i.action);
      item_q.entry_index <= in_i.entry_index;
      item_q.note_period <= in_i.note_period;
      item_q.note_octave <= in_i.note_octave;
      item_q.note_length <= in_i.note_length;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pms_note_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_note_store
// Song memory: one write port, a registered read of the next slot and a
// registered read of slot 0, both with write-through.
// ----------------------------------------------------------------------------
module pms_note_store import pms_pkg::*; #(
  parameter int unsigned SONG_DEPTH = SongDepthDefault,
  parameter int unsigned ENTRY_BITS = PeriodBitsDefault + OctW + LengthBitsDefault,
  localparam int unsigned AW = $clog2(SONG_DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  wr_en_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [ENTRY_BITS-1:0] wr_data_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output logic      [ENTRY_BITS-1:0] rd_data_o,
  output logic      [ENTRY_BITS-1:0] rd0_data_o
);

  logic [ENTRY_BITS-1:0] mem_q [SONG_DEPTH];
  logic [ENTRY_BITS-1:0] rd_q;
  logic [ENTRY_BITS-1:0] rd0_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i && (wr_addr_i == '0)) begin
      rd0_q <= wr_data_i;
    end else begin
      rd0_q <= mem_q[0];
    end
  end

  assign rd_data_o  = rd_q;
  assign rd0_data_o = rd0_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pms_player.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_player
// Playback state and the single-pass update for one command item: note
// writes, start, stop, and the per-tick wave and length counters.
// ----------------------------------------------------------------------------
module pms_player import pms_pkg::*; #(
  parameter int unsigned SONG_DEPTH  = SongDepthDefault,
  parameter int unsigned PERIOD_BITS = PeriodBitsDefault,
  parameter int unsigned LENGTH_BITS = LengthBitsDefault,
  localparam int unsigned AW  = $clog2(SONG_DEPTH),
  localparam int unsigned NSW = $clog2(SONG_DEPTH + 1),
  localparam int unsigned EW  = PERIOD_BITS + OctW + LENGTH_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pms_item_t     item_i,
  input  wire logic          adv_i,
  input  wire logic [EW-1:0] rd_data_i,
  input  wire logic [EW-1:0] rd0_data_i,
  output logic               wr_en_o,
  output logic      [AW-1:0] wr_addr_o,
  output logic      [EW-1:0] wr_data_o,
  output logic      [AW-1:0] rd_addr_o,
  output pms_result_t        result_o
);

  logic                   playing_q, playing_d;
  logic [NSW-1:0]         next_slot_q, next_slot_d;
  logic [PERIOD_BITS-1:0] tone_period_q, tone_period_d;
  logic [PERIOD_BITS-1:0] wave_counter_q, wave_counter_d;
  logic [LENGTH_BITS-1:0] ticks_left_q, ticks_left_d;

  logic                   load_start;
  logic                   load_req;
  logic                   halt;
  logic                   done;
  logic [EW-1:0]          entry;
  logic [NSW-1:0]         slot;
  logic [PERIOD_BITS-1:0] e_period;
  logic [OctW-1:0]        e_octave;
  logic [LENGTH_BITS-1:0] e_length;
  logic [PERIOD_BITS-1:0] shifted;
  logic                   song_end;

  // Start reads slot 0 from its own port; a tick reads the prefetched slot.
  assign entry    = load_start ? rd0_data_i : rd_data_i;
  assign slot     = load_start ? NSW'(0) : next_slot_q;
  assign e_period = entry[EW-1 -: PERIOD_BITS];
  assign e_octave = entry[LENGTH_BITS +: OctW];
  assign e_length = entry[LENGTH_BITS-1:0];
  assign shifted  = e_period >> e_octave;
  assign song_end = (slot >= NSW'(SONG_DEPTH)) ||
                    ((shifted == '0) && (e_length == '0));

  assign wr_addr_o = AW'(item_i.entry_index);
  assign wr_data_o = {PERIOD_BITS'(item_i.note_period), item_i.note_octave,
                      LENGTH_BITS'(item_i.note_length)};

  always_comb begin
    playing_d      = playing_q;
    next_slot_d    = next_slot_q;
    tone_period_d  = tone_period_q;
    wave_counter_d = wave_counter_q;
    ticks_left_d   = ticks_left_q;
    load_start     = 1'b0;
    load_req       = 1'b0;
    halt           = 1'b0;
    done           = 1'b0;
    wr_en_o        = 1'b0;

    if (adv_i) begin
      unique case (item_i.action)
        ActWrite: wr_en_o = (32'(item_i.entry_index) < SONG_DEPTH);
        ActStart: begin
          load_start = 1'b1;
          load_req   = 1'b1;
        end
        ActStop:  halt = 1'b1;
        ActTick: begin
          if (playing_q) begin
            if ((tone_period_q == '0) || (wave_counter_q >= tone_period_q - 1'b1)) begin
              wave_counter_d = '0;
            end else begin
              wave_counter_d = wave_counter_q + 1'b1;
            end
            if (ticks_left_q <= LENGTH_BITS'(1)) begin
              load_req = 1'b1;
            end else begin
              ticks_left_d = ticks_left_q - 1'b1;
            end
          end
        end
        default: halt = 1'b1;
      endcase
    end

    if (load_req) begin
      if (song_end) begin
        halt = 1'b1;
        done = 1'b1;
      end else begin
        playing_d      = 1'b1;
        tone_period_d  = shifted;
        ticks_left_d   = e_length;
        wave_counter_d = '0;
        next_slot_d    = slot + NSW'(1);
      end
    end

    if (halt) begin
      playing_d      = 1'b0;
      next_slot_d    = '0;
      tone_period_d  = '0;
      wave_counter_d = '0;
      ticks_left_d   = '0;
    end
  end

  // Prefetch the slot that the next load will need.
  assign rd_addr_o = AW'(next_slot_d);

  always_comb begin
    result_o.tone_out     = playing_d && (tone_period_d != '0) &&
                            (wave_counter_d < (tone_period_d >> 1));
    result_o.busy_res     = playing_d;
    result_o.current_slot = IdxW'(next_slot_d);
    result_o.song_done    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q      <= 1'b0;
      next_slot_q    <= '0;
      tone_period_q  <= '0;
      wave_counter_q <= '0;
      ticks_left_q   <= '0;
    end else begin
      playing_q      <= playing_d;
      next_slot_q    <= next_slot_d;
      tone_period_q  <= tone_period_d;
      wave_counter_q <= wave_counter_d;
      ticks_left_q   <= ticks_left_d;
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && result_o.song_done) |-> !result_o.busy_res)
    else $error("done raised while still playing");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> ((next_slot_q == '0) && (tone_period_q == '0) &&
                    (wave_counter_q == '0) && (ticks_left_q == '0)))
    else $error("idle player holds stale note state");

  a_slot_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> ((next_slot_q != '0) && (next_slot_q <= NSW'(SONG_DEPTH))))
    else $error("playing without a loaded slot");

  a_wave_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (playing_q && (tone_period_q != '0)) |-> (wave_counter_q < tone_period_q))
    else $error("wave counter past its period");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(next_slot_q) && $stable(playing_q) && $stable(ticks_left_q)))
    else $error("state moved without an item");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/pms_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module pms_out_stage import pms_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire pms_result_t result_i,
  output logic             can_load_o,
  pms_result_if.source     out_o
);

  logic        valid_q;
  pms_result_t data_q;

  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.tone_out     = data_q.tone_out;
  assign out_o.busy_res     = data_q.busy_res;
  assign out_o.current_slot = data_q.current_slot;
  assign out_o.song_done    = data_q.song_done;

endmodule
`default_nettype wire

// ===== hw/rtl/pwm_melody_sequencer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_melody_sequencer_core
// Square-wave melody player driven by write, start, stop and tick items.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle unless the sink stalls the result path,
// passing an input register, one pass through the player update, and a result
// register. The note store is a memory read through a registered port that
// always prefetches the slot the next load will use, plus a second port that
// holds slot 0 for start; writes pass straight through to both. The store
// has no reset and needs no clearing pass, so the block takes items right
// after reset.
// ----------------------------------------------------------------------------
module pwm_melody_sequencer_core import pms_pkg::*; #(
  parameter int unsigned SONG_DEPTH  = SongDepthDefault,
  parameter int unsigned PERIOD_BITS = PeriodBitsDefault,
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pms_item_if.sink     in_i,
  pms_result_if.source out_o
);

  localparam int unsigned AW = $clog2(SONG_DEPTH);
  localparam int unsigned EW = PERIOD_BITS + OctW + LENGTH_BITS;

  pms_item_t   item;
  logic        item_valid;
  logic        can_load;
  logic        adv;
  pms_result_t result;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] rd0_data;

  assign adv = item_valid && can_load;

  pms_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .item_o  (item),
    .valid_o (item_valid)
  );

  pms_note_store #(
    .SONG_DEPTH (SONG_DEPTH),
    .ENTRY_BITS (EW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .rd0_data_o (rd0_data)
  );

  pms_player #(
    .SONG_DEPTH  (SONG_DEPTH),
    .PERIOD_BITS (PERIOD_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_player (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .adv_i      (adv),
    .rd_data_i  (rd_data),
    .rd0_data_i (rd0_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .result_o   (result)
  );

  pms_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (adv),
    .result_i   (result),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire
